>>> sv/rgbhsl_pkg.sv
// Shared types and constants of the RGB to HSL converter.
`timescale 1ns / 1ps

package rgbhsl_pkg;

  // Input word: one 8-bit RGB pixel.
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  // Output word: hue in degrees, saturation and lightness in percent.
  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] light_pct;
  } hsl_t;

  // Divider geometry. The largest dividend is 60 * 6 * 255 = 91800, the
  // largest divisor 510, and every quotient stays below 512.
  localparam int unsigned DivNumW    = 17;
  localparam int unsigned DivDenW    = 10;
  localparam int unsigned DivQuoW    = 9;
  localparam int unsigned DivStages  = DivQuoW;
  localparam int unsigned DivCmpW    = DivDenW + DivQuoW;

  // Front stages ahead of the divider: channel sort, differences, products.
  localparam int unsigned FrontStages = 3;
  localparam int unsigned PipeDepth   = FrontStages + DivStages;

endpackage

>>> sv/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module rgbhsl_div (
  input  logic                               clk_i,
  input  logic [rgbhsl_pkg::DivNumW-1:0]     num_i,
  input  logic [rgbhsl_pkg::DivDenW-1:0]     den_i,
  output logic [rgbhsl_pkg::DivQuoW-1:0]     quo_o
);
  import rgbhsl_pkg::*;

  logic [DivNumW-1:0] rem_q [DivStages];
  logic [DivDenW-1:0] den_q [DivStages];
  logic [DivQuoW-1:0] quo_q [DivStages];

  // Stage s decides quotient bit DivQuoW-1-s, most significant bit first.
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    localparam int unsigned Bit = DivQuoW - 1 - s;

    logic [DivNumW-1:0] rem_in;
    logic [DivDenW-1:0] den_in;
    logic [DivQuoW-1:0] quo_in;
    logic [DivCmpW-1:0] trial;
    logic [DivCmpW-1:0] rem_ext;
    logic               fits;
    logic [DivNumW-1:0] rem_d;
    logic [DivQuoW-1:0] quo_d;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      trial   = DivCmpW'(den_in) << Bit;
      rem_ext = DivCmpW'(rem_in);
      fits    = (rem_ext >= trial);
      rem_d   = fits ? DivNumW'(rem_ext - trial) : rem_in;
      quo_d   = quo_in;
      quo_d[Bit] = fits;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      den_q[s] <= den_in;
      quo_q[s] <= quo_d;
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

>>> sv/rgb_to_hsl_converter.sv
// Top level of the RGB to HSL converter: channel sort, products and dividers.
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per clock into hue in whole degrees
// (truncated), and saturation and lightness in whole percent (rounded half
// up). A word is taken at every rising edge where start_i is high; busy_o
// is never raised, so a new pixel may follow in every cycle. Each result
// appears on result_o for exactly one cycle, marked by done_o, once its
// pixel has passed through every pipeline stage; results leave in pixel
// order. The receiver cannot stall the block and must take each result as
// it comes.
// The pipeline has three front stages (channel sort, sum and
// difference, constant products) followed by a nine-stage restoring
// divider that resolves one quotient bit per stage. Two dividers run side
// by side for hue and saturation; lightness comes from a multiplication by
// a scaled reciprocal in the third stage and is delayed to line up with
// them. For a grey pixel, where all channels are equal, hue and saturation
// read as zero.
module rgb_to_hsl_converter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  rgbhsl_pkg::pixel_t      pixel_i,
  output logic                    done_o,
  output rgbhsl_pkg::hsl_t        result_o
);
  import rgbhsl_pkg::*;

  // Which channel is the maximum; red wins ties over green, green over blue.
  typedef enum logic [1:0] {
    MaxRed   = 2'd0,
    MaxGreen = 2'd1,
    MaxBlue  = 2'd2
  } max_sel_e;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Valid bits of every pipeline stage, and the grey flag beside the divider.
  logic [PipeDepth-1:0] valid_q, valid_d;
  logic [DivStages-1:0] grey_q, grey_d;

  // Stage 1: sort the channels and pick the operands of the hue numerator.
  logic [7:0] hi_d, lo_d, pa_d, pb_d;
  logic       wrap_d;
  max_sel_e   sel_d;
  logic [7:0] hi_q, lo_q, pa_q, pb_q;
  logic       wrap_q;
  max_sel_e   sel_q;

  always_comb begin
    logic [7:0] r, g, b;
    r = pixel_i.red_in;
    g = pixel_i.green_in;
    b = pixel_i.blue_in;
    wrap_d = 1'b0;
    if (r >= g && r >= b) begin
      sel_d  = MaxRed;
      hi_d   = r;
      pa_d   = g;
      pb_d   = b;
      wrap_d = (g < b);
    end else if (g >= b) begin
      sel_d = MaxGreen;
      hi_d  = g;
      pa_d  = b;
      pb_d  = r;
    end else begin
      sel_d = MaxBlue;
      hi_d  = b;
      pa_d  = r;
      pb_d  = g;
    end
    lo_d = r;
    if (g < lo_d) lo_d = g;
    if (b < lo_d) lo_d = b;
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    wrap_q <= wrap_d;
    sel_q  <= sel_d;
  end

  // Stage 2: sum, difference and the hue numerator in units of sixty degrees.
  // The numerator is sector * diff + pa - pb, which never goes negative.
  logic [8:0]  sum_d, sum_q;
  logic [7:0]  diff_d, diff_q;
  logic [10:0] hnum_d, hnum_q;

  always_comb begin
    logic [10:0] base;
    sum_d  = 9'(hi_q) + 9'(lo_q);
    diff_d = hi_q - lo_q;
    unique case (sel_q)
      MaxRed:   base = wrap_q ? 11'(diff_d) * 11'd6 : 11'd0;
      MaxGreen: base = 11'(diff_d) * 11'd2;
      MaxBlue:  base = 11'(diff_d) * 11'd4;
      default:  base = '0;
    endcase
    hnum_d = base + 11'(pa_q) - 11'(pb_q);
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    diff_q <= diff_d;
    hnum_q <= hnum_d;
  end

  // Stage 3: dividends, divisors and lightness. A rounded-half-up ratio n / d
  // is taken as floor((2n + d) / 2d); with the factor 100 folded in,
  // saturation is floor((200 diff + den) / 2 den). Lightness is
  // floor((20 sum + 51) / 102), found by multiplying with 10281, which is
  // 2^20 / 102 rounded up, and keeping the bits from 20 up. The error of
  // that reciprocal stays below one step for every sum up to 510.
  logic [DivNumW-1:0] hue_num_d, sat_num_d;
  logic [DivNumW-1:0] hue_num_q, sat_num_q;
  logic [DivDenW-1:0] hue_den_d, sat_den_d;
  logic [DivDenW-1:0] hue_den_q, sat_den_q;
  logic [6:0]         lit3_d, lit3_q;
  logic               grey3_d, grey3_q;

  always_comb begin
    logic [8:0]  sden;
    logic [26:0] lit_prod;
    sden      = (sum_q > 9'd255) ? 9'd510 - sum_q : sum_q;
    hue_num_d = DivNumW'(hnum_q) * DivNumW'(60);
    hue_den_d = DivDenW'(diff_q);
    sat_num_d = DivNumW'(diff_q) * DivNumW'(200) + DivNumW'(sden);
    sat_den_d = DivDenW'(sden) << 1;
    // 205620 = 20 * 10281 and 524331 = 51 * 10281.
    lit_prod  = 27'(sum_q) * 27'd205620 + 27'd524331;
    lit3_d    = lit_prod[26:20];
    grey3_d   = (diff_q == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    hue_num_q <= hue_num_d;
    hue_den_q <= hue_den_d;
    sat_num_q <= sat_num_d;
    sat_den_q <= sat_den_d;
    lit3_q    <= lit3_d;
    grey3_q   <= grey3_d;
  end

  // Division stages. Divisors are zero only for a grey pixel, whose hue and
  // saturation are masked at the output.
  logic [DivQuoW-1:0] hue_quo, sat_quo;

  rgbhsl_div u_hue_div (
    .clk_i (clk_i),
    .num_i (hue_num_q),
    .den_i (hue_den_q),
    .quo_o (hue_quo)
  );

  rgbhsl_div u_sat_div (
    .clk_i (clk_i),
    .num_i (sat_num_q),
    .den_i (sat_den_q),
    .quo_o (sat_quo)
  );

  // Control line: valid bits for every stage, grey flag and lightness beside
  // the divider.
  logic [DivStages-1:0][6:0] lit_pipe_q, lit_pipe_d;

  assign valid_d    = {valid_q[PipeDepth-2:0], accept};
  assign grey_d     = {grey_q[DivStages-2:0], grey3_q};
  assign lit_pipe_d = {lit_pipe_q[DivStages-2:0], lit3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grey_q     <= grey_d;
    lit_pipe_q <= lit_pipe_d;
  end

  // Output word, driven from the last divider stage and the lightness line beside it.
  always_comb begin
    result_o.hue_deg   = grey_q[DivStages-1] ? 9'd0 : hue_quo;
    result_o.sat_pct   = grey_q[DivStages-1] ? 7'd0 : sat_quo[6:0];
    result_o.light_pct = lit_pipe_q[DivStages-1];
  end

  assign done_o = valid_q[PipeDepth-1];

endmodule
